### src/cgrp_pkg.sv
// ----------------------------------------------------------------------------
// cgrp_pkg
// Types, codes and helper functions of the composite glyph record parser.
// ----------------------------------------------------------------------------
package cgrp_pkg;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_RECORD = 3'd1,
		PH_ARGS   = 3'd2,
		PH_SCALE  = 3'd3,
		PH_ILEN   = 3'd4,
		PH_IBYTES = 3'd5,
		PH_DONE   = 3'd6,
		PH_SKIP   = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_COMPONENT = 2'd0,
		KIND_OK        = 2'd1,
		KIND_INVALID   = 2'd2,
		KIND_NO_ROOM   = 2'd3
	} kind_t;

	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 16;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_COUNT_ONLY = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CAPACITY   = 1'd1;

	localparam int FLAG_WORDS      = 0;
	localparam int FLAG_XY         = 1;
	localparam int FLAG_SCALE      = 3;
	localparam int FLAG_MORE       = 5;
	localparam int FLAG_XY_SCALE   = 6;
	localparam int FLAG_TWO_BY_TWO = 7;
	localparam int FLAG_INSTR      = 8;

	localparam logic [15:0] ONE_F2_14    = 16'h4000;
	localparam logic [3:0]  HEADER_BYTES = 4'd10;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	typedef struct packed {
		kind_t       result_kind;
		logic [15:0] component_flags;
		logic [15:0] component_glyph;
		logic [16:0] argument_one;
		logic [16:0] argument_two;
		logic [15:0] scale_xx;
		logic [15:0] scale_xy;
		logic [15:0] scale_yx;
		logic [15:0] scale_yy;
		logic [15:0] total_components;
		logic [15:0] instruction_length;
		logic        last_of_run;
	} result_t;

	function automatic logic [3:0] scale_bytes(input logic [15:0] flags);
		logic [3:0] n;
		if (flags[FLAG_SCALE]) n = 4'd2;
		else if (flags[FLAG_XY_SCALE]) n = 4'd4;
		else if (flags[FLAG_TWO_BY_TWO]) n = 4'd8;
		else n = 4'd0;
		return n;
	endfunction

	function automatic logic [16:0] extend_arg(input logic [15:0] raw, input logic word,
		input logic sgn);
		logic [16:0] r;
		if (word) r = {sgn & raw[15], raw};
		else r = {{9{sgn & raw[7]}}, raw[7:0]};
		return r;
	endfunction

endpackage

### src/cgrp_ifs.sv
// ----------------------------------------------------------------------------
// cgrp_ifs
// Byte input and result output channels of the composite glyph record parser.
// ----------------------------------------------------------------------------
interface cgrp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_glyph;

	modport source (output valid, data_byte, end_of_glyph, input ready);
	modport sink (input valid, data_byte, end_of_glyph, output ready);
endinterface

interface cgrp_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         result_kind;
	logic [15:0]        component_flags;
	logic [15:0]        component_glyph;
	logic signed [16:0] argument_one;
	logic signed [16:0] argument_two;
	logic signed [15:0] scale_xx;
	logic signed [15:0] scale_xy;
	logic signed [15:0] scale_yx;
	logic signed [15:0] scale_yy;
	logic [15:0]        total_components;
	logic [15:0]        instruction_length;
	logic               last_of_run;

	modport source (output valid, result_kind, component_flags, component_glyph,
		argument_one, argument_two, scale_xx, scale_xy, scale_yx, scale_yy,
		total_components, instruction_length, last_of_run, input ready);
	modport sink (input valid, result_kind, component_flags, component_glyph,
		argument_one, argument_two, scale_xx, scale_xy, scale_yx, scale_yy,
		total_components, instruction_length, last_of_run, output ready);
endinterface

### src/composite_glyph_record_parser.sv
// ----------------------------------------------------------------------------
// composite_glyph_record_parser
// Parses a composite glyph byte stream into component records and a status.
// ----------------------------------------------------------------------------
// Takes one glyph byte per cycle while the decode stage can advance. A byte
// is registered, then decoded, and its results (none, one component, a final
// status, or a component followed by the status) land in a four-entry result
// queue that drives the output. The decode stage advances only while the queue
// has two free entries; with the output taking one result per cycle the block
// sustains one byte per cycle.
// Components of a glyph are sent before its status and must be dropped by
// the receiver if that status is invalid or insufficient buffer.
module composite_glyph_record_parser #(
	parameter int COUNT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cgrp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [cgrp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	cgrp_in_if.sink                             glyph,
	cgrp_out_if.source                          result
);

	localparam int WIDE = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	logic        count_only_q;
	logic [15:0] capacity_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eog_s1;
	logic       adv;

	cgrp_pkg::phase_t phase_q, phase_d;
	logic [3:0]       hdr_pos_q, hdr_pos_d;
	logic             neg_q, neg_d;
	logic [2:0]       off_q, off_d;
	logic [7:0]       held_q, held_d;
	logic [15:0]      flags_q, flags_d;
	logic [15:0]      glyph_q, glyph_d;
	logic [16:0]      arg_q [2];
	logic [16:0]      arg_d [2];
	logic [15:0]      mat_q [4];
	logic [15:0]      mat_d [4];
	logic [COUNT_BITS-1:0] total_q, total_d;
	logic [15:0]      itotal_q, itotal_d;
	logic [15:0]      ileft_q, ileft_d;
	logic             invalid_q, invalid_d;

	logic                   emit_comp;
	logic [1:0]             push_n;
	cgrp_pkg::result_t      entry0, entry1;

	cgrp_pkg::result_t                  queue_q [cgrp_pkg::QUEUE_DEPTH];
	logic [cgrp_pkg::QUEUE_PTR_W-1:0]   wr_q, rd_q;
	logic [cgrp_pkg::QUEUE_CNT_W-1:0]   cnt_q;
	logic                               pop;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_only_q <= 1'b0;
			capacity_q   <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				cgrp_pkg::CFG_COUNT_ONLY: count_only_q <= cfg_wdata[0];
				cgrp_pkg::CFG_CAPACITY:   capacity_q   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// input register
	assign adv         = valid_s1 && (cnt_q <= cgrp_pkg::QUEUE_CNT_W'(cgrp_pkg::QUEUE_DEPTH - 2));
	assign glyph.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (glyph.ready) begin
			valid_s1 <= glyph.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (glyph.ready && glyph.valid) begin
			byte_s1 <= glyph.data_byte;
			eog_s1  <= glyph.end_of_glyph;
		end
	end

	// decode
	always_comb begin
		logic [15:0]     v16;
		logic            word;
		logic            sgn;
		logic [3:0]      sc_total;
		logic [3:0]      off_inc;
		logic            finish;
		logic [1:0]      k;
		logic [WIDE-1:0] total_w;

		v16      = {held_q, byte_s1};
		word     = flags_q[cgrp_pkg::FLAG_WORDS];
		sgn      = flags_q[cgrp_pkg::FLAG_XY];
		sc_total = cgrp_pkg::scale_bytes(flags_q);
		off_inc  = {1'b0, off_q} + 4'd1;
		finish   = 1'b0;
		k        = off_q[2:1];

		phase_d   = phase_q;
		hdr_pos_d = hdr_pos_q;
		neg_d     = neg_q;
		off_d     = off_q;
		held_d    = held_q;
		flags_d   = flags_q;
		glyph_d   = glyph_q;
		arg_d     = arg_q;
		mat_d     = mat_q;
		total_d   = total_q;
		itotal_d  = itotal_q;
		ileft_d   = ileft_q;
		invalid_d = invalid_q;

		case (phase_q)
			cgrp_pkg::PH_HEADER: begin
				if (hdr_pos_q == 4'd0) neg_d = byte_s1[7];
				hdr_pos_d = hdr_pos_q + 4'd1;
				if (hdr_pos_d >= cgrp_pkg::HEADER_BYTES) begin
					off_d = 3'd0;
					if (neg_d) begin
						phase_d = cgrp_pkg::PH_RECORD;
					end else begin
						invalid_d = 1'b1;
						phase_d   = cgrp_pkg::PH_SKIP;
					end
				end
			end
			cgrp_pkg::PH_RECORD: begin
				if (!off_q[0]) held_d = byte_s1;
				else if (off_q == 3'd1) flags_d = v16;
				else glyph_d = v16;
				off_d = off_inc[2:0];
				if (off_q >= 3'd3) begin
					phase_d  = cgrp_pkg::PH_ARGS;
					off_d    = 3'd0;
					arg_d[0] = '0;
					arg_d[1] = '0;
					mat_d[0] = cgrp_pkg::ONE_F2_14;
					mat_d[1] = '0;
					mat_d[2] = '0;
					mat_d[3] = cgrp_pkg::ONE_F2_14;
				end
			end
			cgrp_pkg::PH_ARGS: begin
				if (word) begin
					if (!off_q[0]) held_d = byte_s1;
					else arg_d[off_q[1]] = cgrp_pkg::extend_arg(v16, 1'b1, sgn);
				end else begin
					arg_d[off_q[0]] = cgrp_pkg::extend_arg({8'h00, byte_s1}, 1'b0, sgn);
				end
				off_d = off_inc[2:0];
				if (off_inc >= (word ? 4'd4 : 4'd2)) begin
					off_d = 3'd0;
					if (sc_total == 4'd0) finish = 1'b1;
					else phase_d = cgrp_pkg::PH_SCALE;
				end
			end
			cgrp_pkg::PH_SCALE: begin
				if (!off_q[0]) begin
					held_d = byte_s1;
				end else if (sc_total == 4'd2) begin
					mat_d[0] = v16;
					mat_d[3] = v16;
				end else if (sc_total == 4'd4) begin
					if (k == 2'd0) mat_d[0] = v16;
					else mat_d[3] = v16;
				end else begin
					mat_d[k] = v16;
				end
				off_d = off_inc[2:0];
				if (off_inc >= sc_total) finish = 1'b1;
			end
			cgrp_pkg::PH_ILEN: begin
				if (off_q == 3'd0) begin
					held_d = byte_s1;
					off_d  = 3'd1;
				end else begin
					itotal_d = v16;
					ileft_d  = v16;
					off_d    = 3'd0;
					phase_d  = (v16 != 16'd0) ? cgrp_pkg::PH_IBYTES : cgrp_pkg::PH_DONE;
				end
			end
			cgrp_pkg::PH_IBYTES: begin
				if (ileft_q != 16'd0) ileft_d = ileft_q - 16'd1;
				if (ileft_d == 16'd0) phase_d = cgrp_pkg::PH_DONE;
			end
			default: ;
		endcase

		if (finish) begin
			if (total_q != '1) total_d = total_q + COUNT_BITS'(1);
			off_d = 3'd0;
			if (flags_q[cgrp_pkg::FLAG_MORE]) phase_d = cgrp_pkg::PH_RECORD;
			else if (flags_q[cgrp_pkg::FLAG_INSTR]) phase_d = cgrp_pkg::PH_ILEN;
			else phase_d = cgrp_pkg::PH_DONE;
		end
		emit_comp = finish && !count_only_q;

		entry0                 = '0;
		entry0.result_kind     = cgrp_pkg::KIND_COMPONENT;
		entry0.component_flags = flags_d;
		entry0.component_glyph = glyph_d;
		entry0.argument_one    = arg_d[0];
		entry0.argument_two    = arg_d[1];
		entry0.scale_xx        = mat_d[0];
		entry0.scale_xy        = mat_d[1];
		entry0.scale_yx        = mat_d[2];
		entry0.scale_yy        = mat_d[3];
		entry0.last_of_run     = !eog_s1;

		total_w            = WIDE'(total_d);
		entry1             = '0;
		entry1.last_of_run = 1'b1;
		if (invalid_d || phase_d != cgrp_pkg::PH_DONE) begin
			entry1.result_kind = cgrp_pkg::KIND_INVALID;
		end else begin
			entry1.result_kind = (!count_only_q && total_w > WIDE'(capacity_q)) ?
				cgrp_pkg::KIND_NO_ROOM : cgrp_pkg::KIND_OK;
			entry1.total_components   = (total_w > WIDE'(16'hFFFF)) ? 16'hFFFF :
				total_w[15:0];
			entry1.instruction_length = itotal_d;
		end

		if (!emit_comp) entry0 = entry1;
		push_n = {1'b0, emit_comp} + {1'b0, eog_s1};

		if (eog_s1) begin
			phase_d   = cgrp_pkg::PH_HEADER;
			hdr_pos_d = '0;
			neg_d     = 1'b0;
			off_d     = '0;
			held_d    = '0;
			flags_d   = '0;
			glyph_d   = '0;
			arg_d[0]  = '0;
			arg_d[1]  = '0;
			mat_d[0]  = cgrp_pkg::ONE_F2_14;
			mat_d[1]  = '0;
			mat_d[2]  = '0;
			mat_d[3]  = cgrp_pkg::ONE_F2_14;
			total_d   = '0;
			itotal_d  = '0;
			ileft_d   = '0;
			invalid_d = 1'b0;
		end
	end

	// glyph state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= cgrp_pkg::PH_HEADER;
			hdr_pos_q <= '0;
			neg_q     <= 1'b0;
			off_q     <= '0;
			held_q    <= '0;
			flags_q   <= '0;
			glyph_q   <= '0;
			arg_q[0]  <= '0;
			arg_q[1]  <= '0;
			mat_q[0]  <= cgrp_pkg::ONE_F2_14;
			mat_q[1]  <= '0;
			mat_q[2]  <= '0;
			mat_q[3]  <= cgrp_pkg::ONE_F2_14;
			total_q   <= '0;
			itotal_q  <= '0;
			ileft_q   <= '0;
			invalid_q <= 1'b0;
		end else if (adv) begin
			phase_q   <= phase_d;
			hdr_pos_q <= hdr_pos_d;
			neg_q     <= neg_d;
			off_q     <= off_d;
			held_q    <= held_d;
			flags_q   <= flags_d;
			glyph_q   <= glyph_d;
			arg_q     <= arg_d;
			mat_q     <= mat_d;
			total_q   <= total_d;
			itotal_q  <= itotal_d;
			ileft_q   <= ileft_d;
			invalid_q <= invalid_d;
		end
	end

	// result queue
	assign pop = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (adv) wr_q <= wr_q + cgrp_pkg::QUEUE_PTR_W'(push_n);
			if (pop) rd_q <= rd_q + cgrp_pkg::QUEUE_PTR_W'(1);
			cnt_q <= cnt_q + (adv ? cgrp_pkg::QUEUE_CNT_W'(push_n) : '0)
				- (pop ? cgrp_pkg::QUEUE_CNT_W'(1) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && push_n != 2'd0) queue_q[wr_q] <= entry0;
		if (adv && push_n == 2'd2) queue_q[wr_q + cgrp_pkg::QUEUE_PTR_W'(1)] <= entry1;
	end

	assign result.valid              = (cnt_q != '0);
	assign result.result_kind        = queue_q[rd_q].result_kind;
	assign result.component_flags    = queue_q[rd_q].component_flags;
	assign result.component_glyph    = queue_q[rd_q].component_glyph;
	assign result.argument_one       = queue_q[rd_q].argument_one;
	assign result.argument_two       = queue_q[rd_q].argument_two;
	assign result.scale_xx           = queue_q[rd_q].scale_xx;
	assign result.scale_xy           = queue_q[rd_q].scale_xy;
	assign result.scale_yx           = queue_q[rd_q].scale_yx;
	assign result.scale_yy           = queue_q[rd_q].scale_yy;
	assign result.total_components   = queue_q[rd_q].total_components;
	assign result.instruction_length = queue_q[rd_q].instruction_length;
	assign result.last_of_run        = queue_q[rd_q].last_of_run;

	// checks
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cgrp_pkg::QUEUE_CNT_W'(cgrp_pkg::QUEUE_DEPTH))
		else $error("result queue overflow");

	a_status_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.result_kind != cgrp_pkg::KIND_COMPONENT |-> result.last_of_run)
		else $error("status result without end of run");

	a_glyph_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eog_s1 |=> phase_q == cgrp_pkg::PH_HEADER && total_q == '0 && !invalid_q)
		else $error("glyph state not cleared after last byte");

	a_count_only_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		adv && count_only_q |-> !emit_comp)
		else $error("component emitted in count-only mode");

	a_skip_no_records: assert property (@(posedge clk) disable iff (!arst_n)
		adv && invalid_q |-> !emit_comp)
		else $error("component emitted for invalid glyph");

endmodule

### verif/cgrp_result_checker.sv
// ----------------------------------------------------------------------------
// cgrp_result_checker
// Watches the byte and result channels of the composite glyph record parser,
// decodes every accepted byte with its own copy of the parser state and the
// two configuration registers, and compares each result transaction field by
// field against the oldest predicted result.
// ----------------------------------------------------------------------------
module cgrp_result_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cgrp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [cgrp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	cgrp_in_if                                  glyph,
	cgrp_out_if                                 result,
	output int                                  pending,
	output int                                  failures
);

	logic        count_only;
	logic [15:0] capacity;

	logic             [3:0]  hdr_count;
	logic                    contour_neg;
	cgrp_pkg::phase_t        phase;
	logic             [3:0]  rec_off;
	logic             [7:0]  hi_byte;
	logic             [15:0] flags_w;
	logic             [15:0] glyph_w;
	logic             [16:0] arg_w [2];
	logic             [15:0] mtx_w [4];
	logic             [15:0] comp_count;
	logic             [15:0] instr_len;
	logic             [15:0] instr_left;
	logic                    bad_glyph;

	cgrp_pkg::result_t comp_res;
	logic              comp_made;
	cgrp_pkg::result_t awaited_results [$];

	task automatic load_identity;
		mtx_w[0] = cgrp_pkg::ONE_F2_14;
		mtx_w[1] = 16'd0;
		mtx_w[2] = 16'd0;
		mtx_w[3] = cgrp_pkg::ONE_F2_14;
	endtask

	task automatic clear_glyph;
		hdr_count = 4'd0;
		contour_neg = 1'b0;
		phase = cgrp_pkg::PH_HEADER;
		rec_off = 4'd0;
		hi_byte = 8'd0;
		flags_w = 16'd0;
		glyph_w = 16'd0;
		arg_w[0] = 17'd0;
		arg_w[1] = 17'd0;
		load_identity();
		comp_count = 16'd0;
		instr_len = 16'd0;
		instr_left = 16'd0;
		bad_glyph = 1'b0;
	endtask

	// first matching flag wins: uniform, then x/y, then 2x2
	function automatic int matrix_bytes(input logic [15:0] f);
		int n;
		if (f[cgrp_pkg::FLAG_SCALE]) n = 2;
		else if (f[cgrp_pkg::FLAG_XY_SCALE]) n = 4;
		else if (f[cgrp_pkg::FLAG_TWO_BY_TWO]) n = 8;
		else n = 0;
		return n;
	endfunction

	task automatic close_record;
		if (comp_count != 16'hFFFF) comp_count = comp_count + 16'd1;
		if (!count_only) begin
			comp_res = '0;
			comp_res.result_kind = cgrp_pkg::KIND_COMPONENT;
			comp_res.component_flags = flags_w;
			comp_res.component_glyph = glyph_w;
			comp_res.argument_one = arg_w[0];
			comp_res.argument_two = arg_w[1];
			comp_res.scale_xx = mtx_w[0];
			comp_res.scale_xy = mtx_w[1];
			comp_res.scale_yx = mtx_w[2];
			comp_res.scale_yy = mtx_w[3];
			comp_made = 1'b1;
		end
		rec_off = 4'd0;
		if (flags_w[cgrp_pkg::FLAG_MORE]) phase = cgrp_pkg::PH_RECORD;
		else if (flags_w[cgrp_pkg::FLAG_INSTR]) phase = cgrp_pkg::PH_ILEN;
		else phase = cgrp_pkg::PH_DONE;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic eog);
		cgrp_pkg::result_t st;
		logic [3:0]        o;
		logic [15:0]       w16;
		int                span;
		o = rec_off;
		w16 = {hi_byte, b};
		comp_made = 1'b0;
		case (phase)
			cgrp_pkg::PH_HEADER: begin
				if (hdr_count == 4'd0) contour_neg = b[7];
				hdr_count = hdr_count + 4'd1;
				if (hdr_count >= cgrp_pkg::HEADER_BYTES) begin
					rec_off = 4'd0;
					if (contour_neg) begin
						phase = cgrp_pkg::PH_RECORD;
					end else begin
						bad_glyph = 1'b1;
						phase = cgrp_pkg::PH_SKIP;
					end
				end
			end
			cgrp_pkg::PH_RECORD: begin
				if (!o[0]) hi_byte = b;
				else if (o == 4'd1) flags_w = w16;
				else glyph_w = w16;
				rec_off = o + 4'd1;
				if (o >= 4'd3) begin
					phase = cgrp_pkg::PH_ARGS;
					rec_off = 4'd0;
					arg_w[0] = 17'd0;
					arg_w[1] = 17'd0;
					load_identity();
				end
			end
			cgrp_pkg::PH_ARGS: begin
				if (flags_w[cgrp_pkg::FLAG_WORDS]) begin
					if (!o[0]) hi_byte = b;
					else if (flags_w[cgrp_pkg::FLAG_XY]) arg_w[o[1]] = 17'($signed(w16));
					else arg_w[o[1]] = {1'b0, w16};
				end else begin
					if (flags_w[cgrp_pkg::FLAG_XY]) arg_w[o[0]] = 17'($signed(b));
					else arg_w[o[0]] = {9'd0, b};
				end
				rec_off = o + 4'd1;
				if (rec_off >= (flags_w[cgrp_pkg::FLAG_WORDS] ? 4'd4 : 4'd2)) begin
					rec_off = 4'd0;
					if (matrix_bytes(flags_w) == 0) close_record();
					else phase = cgrp_pkg::PH_SCALE;
				end
			end
			cgrp_pkg::PH_SCALE: begin
				span = matrix_bytes(flags_w);
				if (!o[0]) begin
					hi_byte = b;
				end else if (span == 2) begin
					mtx_w[0] = w16;
					mtx_w[3] = w16;
				end else if (span == 4) begin
					if (o[2:1] == 2'd0) mtx_w[0] = w16;
					else mtx_w[3] = w16;
				end else begin
					mtx_w[o[2:1]] = w16;
				end
				rec_off = o + 4'd1;
				if (rec_off >= span) close_record();
			end
			cgrp_pkg::PH_ILEN: begin
				if (o == 4'd0) begin
					hi_byte = b;
					rec_off = 4'd1;
				end else begin
					instr_len = w16;
					instr_left = w16;
					rec_off = 4'd0;
					phase = (w16 != 16'd0) ? cgrp_pkg::PH_IBYTES : cgrp_pkg::PH_DONE;
				end
			end
			cgrp_pkg::PH_IBYTES: begin
				if (instr_left != 16'd0) instr_left = instr_left - 16'd1;
				if (instr_left == 16'd0) phase = cgrp_pkg::PH_DONE;
			end
			default: begin
			end
		endcase
		if (eog) begin
			st = '0;
			if (bad_glyph || phase != cgrp_pkg::PH_DONE) begin
				st.result_kind = cgrp_pkg::KIND_INVALID;
			end else begin
				if (!count_only && comp_count > capacity) st.result_kind = cgrp_pkg::KIND_NO_ROOM;
				else st.result_kind = cgrp_pkg::KIND_OK;
				st.total_components = comp_count;
				st.instruction_length = instr_len;
			end
			st.last_of_run = 1'b1;
			if (comp_made) awaited_results.push_back(comp_res);
			awaited_results.push_back(st);
			clear_glyph();
		end else if (comp_made) begin
			comp_res.last_of_run = 1'b1;
			awaited_results.push_back(comp_res);
		end
	endtask

	function automatic bit field_ok(input string name, input logic [16:0] want,
		input logic [16:0] got);
		if (want !== got) begin
			$display("%0t %s: expected %0h, got %0h", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic check_result;
		cgrp_pkg::result_t want;
		cgrp_pkg::result_t got;
		bit                ok;
		got.result_kind = cgrp_pkg::kind_t'(result.result_kind);
		got.component_flags = result.component_flags;
		got.component_glyph = result.component_glyph;
		got.argument_one = result.argument_one;
		got.argument_two = result.argument_two;
		got.scale_xx = result.scale_xx;
		got.scale_xy = result.scale_xy;
		got.scale_yx = result.scale_yx;
		got.scale_yy = result.scale_yy;
		got.total_components = result.total_components;
		got.instruction_length = result.instruction_length;
		got.last_of_run = result.last_of_run;
		if (awaited_results.size() == 0) begin
			$display("%0t result: expected none, got kind %0d", $time, result.result_kind);
			failures++;
		end else begin
			want = awaited_results.pop_front();
			ok = 1'b1;
			ok &= field_ok("result_kind", want.result_kind, got.result_kind);
			ok &= field_ok("component_flags", want.component_flags, got.component_flags);
			ok &= field_ok("component_glyph", want.component_glyph, got.component_glyph);
			ok &= field_ok("argument_one", want.argument_one, got.argument_one);
			ok &= field_ok("argument_two", want.argument_two, got.argument_two);
			ok &= field_ok("scale_xx", want.scale_xx, got.scale_xx);
			ok &= field_ok("scale_xy", want.scale_xy, got.scale_xy);
			ok &= field_ok("scale_yx", want.scale_yx, got.scale_yx);
			ok &= field_ok("scale_yy", want.scale_yy, got.scale_yy);
			ok &= field_ok("total_components", want.total_components, got.total_components);
			ok &= field_ok("instruction_length", want.instruction_length,
				got.instruction_length);
			ok &= field_ok("last_of_run", want.last_of_run, got.last_of_run);
			if (!ok) failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_glyph();
			count_only = 1'b0;
			capacity = 16'hFFFF;
			awaited_results.delete();
			failures = 0;
		end else begin
			if (result.valid && result.ready) check_result();
			if (glyph.valid && glyph.ready) decode_byte(glyph.data_byte, glyph.end_of_glyph);
			if (cfg_we) begin
				if (cfg_index == cgrp_pkg::CFG_COUNT_ONLY) count_only = cfg_wdata[0];
				else if (cfg_index == cgrp_pkg::CFG_CAPACITY) capacity = cfg_wdata;
			end
		end
		pending <= awaited_results.size();
	end

endmodule

### verif/tb_composite_glyph_record_parser.sv
// ----------------------------------------------------------------------------
// tb_composite_glyph_record_parser
// Drives glyph byte streams into the composite glyph record parser: directed
// headers, record layouts, truncations and capacity cases, then random glyph
// mixes under several register settings. Checking is done by
// cgrp_result_checker.
// ----------------------------------------------------------------------------
module tb_composite_glyph_record_parser;

	localparam int LIMIT = 20000;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_we;
	logic [cgrp_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [cgrp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;

	int pending;
	int failures;
	int idle_pct;
	int stall_pct;

	// {end_of_glyph, data_byte}
	logic [8:0] stream [$];

	cgrp_in_if  glyph_ch ();
	cgrp_out_if result_ch ();

	composite_glyph_record_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.glyph    (glyph_ch),
		.result   (result_ch)
	);

	cgrp_result_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.glyph    (glyph_ch),
		.result   (result_ch),
		.pending  (pending),
		.failures (failures)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("[composite_glyph_record_parser] ERROR");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_ch.ready <= 1'b0;
		else result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic push_byte(input logic [7:0] b);
		stream.push_back({1'b0, b});
	endtask

	task automatic push_word(input logic [15:0] w);
		push_byte(w[15:8]);
		push_byte(w[7:0]);
	endtask

	task automatic end_glyph;
		stream[stream.size() - 1][8] = 1'b1;
	endtask

	function automatic logic [7:0] fill_byte(input int fill);
		logic [7:0] v;
		if (fill < 0) v = 8'($urandom_range(0, 255));
		else v = 8'(fill);
		return v;
	endfunction

	task automatic push_header(input logic neg);
		logic [6:0] r;
		r = 7'($urandom_range(0, 127));
		push_byte({neg, r});
		repeat (9) push_byte(fill_byte(-1));
	endtask

	// sk: 0 none, 1 uniform, 2 x/y, 3 2x2; wx: {xy values, words}
	task automatic push_record(input logic more, input logic instr, input int sk,
		input logic [1:0] wx, input int fill);
		logic [15:0] f;
		f = 16'($urandom_range(0, 65535));
		f[cgrp_pkg::FLAG_SCALE] = (sk == 1);
		f[cgrp_pkg::FLAG_XY_SCALE] = (sk == 2) || (sk == 1 && f[cgrp_pkg::FLAG_XY_SCALE]);
		f[cgrp_pkg::FLAG_TWO_BY_TWO] = (sk == 3) || (sk != 0 && f[cgrp_pkg::FLAG_TWO_BY_TWO]);
		f[cgrp_pkg::FLAG_WORDS] = wx[0];
		f[cgrp_pkg::FLAG_XY] = wx[1];
		f[cgrp_pkg::FLAG_MORE] = more;
		f[cgrp_pkg::FLAG_INSTR] = instr;
		push_word(f);
		push_byte(fill_byte(fill));
		push_byte(fill_byte(fill));
		repeat (wx[0] ? 4 : 2) push_byte(fill_byte(fill));
		repeat (sk == 0 ? 0 : (1 << sk)) push_byte(fill_byte(fill));
	endtask

	task automatic add_good(input int n, input int ilen, input int trail);
		int k;
		push_header(1'b1);
		for (k = 0; k < n; k++) begin
			push_record(k < n - 1, (k < n - 1) ? 1'($urandom_range(0, 1)) : (ilen >= 0),
				$urandom_range(0, 3), 2'($urandom_range(0, 3)), -1);
		end
		if (ilen >= 0) begin
			push_word(16'(ilen));
			repeat (ilen) push_byte(fill_byte(-1));
		end
		repeat (trail) push_byte(fill_byte(-1));
		end_glyph();
	endtask

	task automatic add_random_glyph;
		int pick;
		int n;
		int s;
		int cut;
		pick = $urandom_range(0, 99);
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
		if (pick < 65) begin
			add_good(n, $urandom_range(0, 1) ? $urandom_range(0, 5) : -1,
				($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
		end else if (pick < 77) begin
			s = stream.size();
			add_good(n, $urandom_range(0, 1) ? $urandom_range(0, 5) : -1, 0);
			cut = $urandom_range(1, stream.size() - s - 1);
			while (stream.size() > s + cut) stream.delete(stream.size() - 1);
			end_glyph();
		end else if (pick < 85) begin
			push_header(1'b0);
			repeat ($urandom_range(0, 8)) push_byte(fill_byte(-1));
			end_glyph();
		end else if (pick < 92) begin
			push_header(1'b1);
			push_record(1'b0, 1'b1, $urandom_range(0, 3), 2'($urandom_range(0, 3)), -1);
			push_word(16'($urandom_range(0, 65535)));
			repeat ($urandom_range(0, 4)) push_byte(fill_byte(-1));
			end_glyph();
		end else begin
			repeat ($urandom_range(1, 16)) push_byte(fill_byte(-1));
			end_glyph();
		end
	endtask

	task automatic feed_bytes;
		int i;
		for (i = 0; i < stream.size(); i++) begin
			if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				glyph_ch.valid <= 1'b0;
				@(posedge clk);
			end
			glyph_ch.valid <= 1'b1;
			glyph_ch.data_byte <= stream[i][7:0];
			glyph_ch.end_of_glyph <= stream[i][8];
			@(posedge clk);
			while (!glyph_ch.ready) @(posedge clk);
		end
		glyph_ch.valid <= 1'b0;
		stream.delete();
	endtask

	task automatic wait_quiet;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_config(input logic co, input logic [15:0] cap);
		cfg_we <= 1'b1;
		cfg_index <= cgrp_pkg::CFG_COUNT_ONLY;
		cfg_wdata <= {15'd0, co};
		@(posedge clk);
		cfg_index <= cgrp_pkg::CFG_CAPACITY;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int ph;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = cgrp_pkg::CFG_COUNT_ONLY;
		cfg_wdata = '0;
		glyph_ch.valid = 1'b0;
		glyph_ch.data_byte = 8'd0;
		glyph_ch.end_of_glyph = 1'b0;
		idle_pct = 10;
		stall_pct = 10;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header-only and truncated glyphs
		push_byte(8'h80);
		end_glyph();
		push_header(1'b1);
		end_glyph();
		// every scale layout and argument encoding with extreme contents, then instruction, header and truncation cases
		push_header(1'b1);
		push_record(1'b1, 1'b0, 0, 2'b00, 8'hFF);
		push_record(1'b1, 1'b1, 1, 2'b01, 8'h80);
		push_record(1'b1, 1'b0, 2, 2'b10, 8'h7F);
		push_record(1'b0, 1'b0, 3, 2'b11, 8'hFF);
		end_glyph();
		push_header(1'b1);
		push_record(1'b1, 1'b1, 3, 2'b10, 8'h80);
		push_record(1'b0, 1'b1, 1, 2'b11, 8'h00);
		push_word(16'd3);
		repeat (5) push_byte(fill_byte(-1));
		end_glyph();
		push_header(1'b1);
		push_record(1'b0, 1'b1, 2, 2'b01, 8'h00);
		push_word(16'd0);
		end_glyph();
		push_header(1'b0);
		repeat (6) push_byte(fill_byte(-1));
		end_glyph();
		push_header(1'b1);
		push_record(1'b0, 1'b0, 0, 2'b11, -1);
		stream.delete(stream.size() - 1);
		stream.delete(stream.size() - 1);
		end_glyph();
		push_header(1'b1);
		push_record(1'b0, 1'b1, 0, 2'b00, -1);
		push_word(16'd5);
		repeat (2) push_byte(fill_byte(-1));
		end_glyph();
		feed_bytes();
		wait_quiet();

		// capacity limits
		set_config(1'b0, 16'd0);
		add_good(1, -1, 0);
		feed_bytes();
		wait_quiet();
		set_config(1'b0, 16'd2);
		add_good(3, -1, 0);
		add_good(2, 1, 0);
		feed_bytes();
		wait_quiet();
		set_config(1'b1, 16'd0);
		add_good(2, 1, 0);
		feed_bytes();
		wait_quiet();

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_config(1'b0, 16'hFFFF);
				1: set_config(1'b1, 16'd0);
				2: set_config(1'b0, 16'd1);
				3: set_config(1'b0, 16'd3);
				4: set_config(1'b0, 16'($urandom_range(0, 6)));
				default: set_config(1'b1, 16'($urandom_range(0, 65535)));
			endcase
			idle_pct = (ph == 3) ? 0 : 10;
			stall_pct = idle_pct;
			while (stream.size() < 50) add_random_glyph();
			feed_bytes();
			wait_quiet();
		end

		if (failures == 0 && pending == 0) begin
			$display("[composite_glyph_record_parser] OK");
		end else begin
			$display("[composite_glyph_record_parser] ERROR");
		end
		$finish;
	end

endmodule
